>>> hdl/tagged_pointer_slot_unit_macros.svh
// ---------------------------------------------------------------------------
// Tagged pointer slot unit: assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef TAGGED_POINTER_SLOT_UNIT_MACROS_SVH
`define TAGGED_POINTER_SLOT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hdl/tps_pkg.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit package
// Command, compare and status codes, defaults and control structs.
// ---------------------------------------------------------------------------
`default_nettype none
package tps_pkg;

  localparam int DEFAULT_SLOT_DEPTH = 256;
  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] CMD_ADDR_OF = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_STORE   = 3'd2;
  localparam logic [2:0] CMD_ADD     = 3'd3;
  localparam logic [2:0] CMD_SUB     = 3'd4;
  localparam logic [2:0] CMD_COMPARE = 3'd5;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NULL_DEREF = 2'd1;
  localparam logic [1:0] ST_NULL_ARITH = 2'd2;
  localparam logic [1:0] ST_INVALID    = 2'd3;

  typedef struct packed {
    logic latch;
    logic issue_read;
    logic commit_exec;
    logic commit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_ok;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/tps_req_if.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit: request channel
// Valid/ready channel carrying one pointer operation per transaction.
// ---------------------------------------------------------------------------
`default_nettype none
interface tps_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] pointer;
  logic [63:0] other_pointer;
  logic [63:0] offset;
  logic [63:0] store_value;
  logic        is_bool;
  logic [7:0]  slot_index;
  logic [2:0]  compare_op;

  modport source (
    output valid, command, pointer, other_pointer, offset, store_value,
           is_bool, slot_index, compare_op,
    input  ready
  );
  modport sink (
    input  valid, command, pointer, other_pointer, offset, store_value,
           is_bool, slot_index, compare_op,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/tps_rsp_if.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit: response channel
// Valid/ready channel carrying one result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none
interface tps_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [1:0]  status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

>>> hdl/tps_datapath.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit: datapath
// Operand registers, capacity register, slot memory, checks and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module tps_datapath #(
  parameter int SLOT_DEPTH = tps_pkg::DEFAULT_SLOT_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wen,
  input  wire logic [tps_pkg::CAP_W-1:0] cfg_wdata,
  input  wire tps_pkg::ctrl_cmd_t      cmd,
  output tps_pkg::dp_sts_t             sts,
  tps_req_if.sink                      request,
  tps_rsp_if.source                    response
);

  localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int BW = $clog2(SLOT_DEPTH + 1);
  localparam int CW = (BW > tps_pkg::CAP_W) ? BW : tps_pkg::CAP_W;

  logic [2:0]  cmd_q;
  logic [63:0] ptr_q;
  logic [63:0] oth_q;
  logic [63:0] off_q;
  logic [63:0] sval_q;
  logic        bool_q;
  logic [7:0]  sidx_q;
  logic [2:0]  cop_q;

  logic [tps_pkg::CAP_W-1:0] cap;
  logic [63:0] mem [SLOT_DEPTH];
  logic [63:0] rdata;

  logic        out_valid;
  logic [63:0] out_value;
  logic [1:0]  out_status;

  logic [CW-1:0] bnd;
  logic [CW-1:0] slot;
  logic [CW-1:0] diff;
  logic [CW-1:0] off_lo;
  logic [CW-1:0] ns_add;
  logic [CW-1:0] ns_sub;
  logic [AW-1:0] addr;
  logic          decode_ok;
  logic          off_hi_nz;
  logic [63:0]   exec_value;
  logic [1:0]    exec_status;
  logic [63:0]   load_value;
  logic [63:0]   sval_norm;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q  <= request.command;
      ptr_q  <= request.pointer;
      oth_q  <= request.other_pointer;
      off_q  <= request.offset;
      sval_q <= request.store_value;
      bool_q <= request.is_bool;
      sidx_q <= request.slot_index;
      cop_q  <= request.compare_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= tps_pkg::CAP_RESET;
    end else if (cfg_wen) begin
      cap <= cfg_wdata;
    end
  end

  always_comb begin
    bnd = (CW'(cap) < CW'(SLOT_DEPTH)) ? CW'(cap) : CW'(SLOT_DEPTH);
    slot = ptr_q[CW:1];
    decode_ok = ptr_q[0] && (ptr_q[63:CW+1] == '0) && (slot < bnd);
    addr = slot[AW-1:0];
    diff = bnd - slot;
    off_lo = off_q[CW-1:0];
    off_hi_nz = |off_q[63:CW];
    ns_add = slot + off_lo;
    ns_sub = slot - off_lo;
    sval_norm = bool_q ? {63'd0, |sval_q} : sval_q;
    load_value = bool_q ? {63'd0, |rdata} : rdata;
  end

  always_comb begin
    exec_value = '0;
    exec_status = tps_pkg::ST_OK;
    case (cmd_q)
      tps_pkg::CMD_ADDR_OF: begin
        exec_value = {55'd0, sidx_q, 1'b1};
      end
      tps_pkg::CMD_LOAD, tps_pkg::CMD_STORE: begin
        if (!decode_ok) exec_status = tps_pkg::ST_NULL_DEREF;
      end
      tps_pkg::CMD_ADD: begin
        if (!decode_ok || off_hi_nz || (off_lo >= diff)) begin
          exec_status = tps_pkg::ST_NULL_ARITH;
        end else begin
          exec_value = 64'({ns_add, 1'b1});
        end
      end
      tps_pkg::CMD_SUB: begin
        if (!decode_ok || off_hi_nz || (off_lo > slot)) begin
          exec_status = tps_pkg::ST_NULL_ARITH;
        end else begin
          exec_value = 64'({ns_sub, 1'b1});
        end
      end
      tps_pkg::CMD_COMPARE: begin
        if (cop_q inside {tps_pkg::CMP_EQ, tps_pkg::CMP_NE}) begin
          exec_value = {63'd0, (cop_q == tps_pkg::CMP_EQ) == (ptr_q == oth_q)};
        end else if (ptr_q == '0 || oth_q == '0) begin
          exec_status = tps_pkg::ST_NULL_DEREF;
        end else begin
          case (cop_q)
            tps_pkg::CMP_LT: exec_value = {63'd0, ptr_q < oth_q};
            tps_pkg::CMP_LE: exec_value = {63'd0, ptr_q <= oth_q};
            tps_pkg::CMP_GT: exec_value = {63'd0, ptr_q > oth_q};
            tps_pkg::CMP_GE: exec_value = {63'd0, ptr_q >= oth_q};
            default:         exec_status = tps_pkg::ST_INVALID;
          endcase
        end
      end
      default: begin
        exec_status = tps_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_exec && cmd_q == tps_pkg::CMD_STORE && decode_ok) begin
      mem[addr] <= sval_norm;
    end
    if (cmd.issue_read) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_exec || cmd.commit_load) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_exec) begin
      out_value  <= exec_value;
      out_status <= exec_status;
    end else if (cmd.commit_load) begin
      out_value  <= load_value;
      out_status <= tps_pkg::ST_OK;
    end
  end

  assign sts.load_ok = (cmd_q == tps_pkg::CMD_LOAD) && decode_ok;
  assign sts.out_free = !out_valid || response.ready;

  assign response.valid = out_valid;
  assign response.result_value = out_value;
  assign response.status = out_status;

endmodule
`default_nettype wire

>>> hdl/tps_ctrl.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit: controller
// Sequences latch, execute and load phases of each transaction.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tagged_pointer_slot_unit_macros.svh"
module tps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tps_pkg::dp_sts_t   sts,
  output tps_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.load_ok) begin
          cmd.issue_read = 1'b1;
          state_next = S_LOAD;
        end else if (sts.out_free) begin
          cmd.commit_exec = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.commit_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  `TPS_ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == S_EXEC, "accept not followed by execute")
  `TPS_ASSERT_NEXT(a_load_phase, clk, rst, state == S_EXEC && sts.load_ok, state == S_LOAD, "load read not followed by load phase")
  `TPS_ASSERT_SAME(a_commit_free, clk, rst, cmd.commit_exec || cmd.commit_load, sts.out_free, "result committed over a pending result")
  `TPS_ASSERT_SAME(a_one_commit, clk, rst, cmd.issue_read, !cmd.commit_exec && !cmd.commit_load, "read issued together with a commit")

endmodule
`default_nettype wire

>>> hdl/tagged_pointer_slot_unit.sv
// ---------------------------------------------------------------------------
// Tagged pointer slot unit
// Pointer operations of a virtual machine over a tagged slot memory.
// ---------------------------------------------------------------------------
// Each request transaction yields one response transaction. A request is
// accepted in the idle state, which latches its operands; its result is
// committed to the output register in the execute state, or for a load that
// passes its checks, after the registered read port of the slot memory, in
// the load state. A result still waiting in the output register holds the
// command in its last state until the response is taken. One request is in
// flight at a time; the next is accepted as soon as the previous result sits
// in the output register, even if that result has not yet been taken. The
// slot memory has no reset and no clearing pass: load only slots that have been
// stored. Write cfg_wdata (slot capacity) only while the unit is idle.
`default_nettype none
module tagged_pointer_slot_unit #(
  parameter int SLOT_DEPTH = tps_pkg::DEFAULT_SLOT_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic [tps_pkg::CAP_W-1:0] cfg_wdata,
  tps_req_if.sink                        request,
  tps_rsp_if.source                      response
);

  tps_pkg::ctrl_cmd_t cmd;
  tps_pkg::dp_sts_t   sts;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tps_datapath #(
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .request   (request),
    .response  (response)
  );

endmodule
`default_nettype wire
